FILE: design/seqrs_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the sequence resequencer
// no dependencies

package seqrs_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ADV,
        ST_SKIP,
        ST_DRAIN_RD,
        ST_DRAIN_OUT
    } t_state;

    typedef enum logic [1:0] {
        STS_DELIVERED = 2'd0,
        STS_LATE      = 2'd1,
        STS_BEYOND    = 2'd2,
        STS_DUP       = 2'd3
    } t_status;

    typedef enum logic {
        ALU_SUB,
        ALU_INC
    } t_alu_op;

    typedef struct packed {
        logic [31:0] sum;
        logic        carry;
    } t_alu_res;

    typedef struct packed {
        logic        func;
        logic [31:0] seq_num;
        logic [31:0] payload_handle;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [31:0] out_seq;
        logic [31:0] out_handle;
        logic        last;
    } t_out_beat;

endpackage

FILE: design/seqrs_alu.sv
`timescale 1ns / 1ps
// shared 32-bit adder: sequence minus expected, or expected plus one
// depends on seqrs_pkg

module seqrs_alu import seqrs_pkg::*; (
    input  t_alu_op     i_op,
    input  logic [31:0] i_seq,
    input  logic [31:0] i_exp,
    output t_alu_res    o_res
);

    logic [31:0] opa;
    logic [31:0] opb;
    logic [32:0] total;

    always_comb begin
        case (i_op)
            ALU_SUB: begin
                opa = i_seq;
                opb = ~i_exp;
            end
            ALU_INC: begin
                opa = i_exp;
                opb = '0;
            end
            default: begin
                opa = i_exp;
                opb = '0;
            end
        endcase
        // carry in of one serves both the two's complement and the increment
        total = {1'b0, opa} + {1'b0, opb} + 33'd1;
        o_res.sum   = total[31:0];
        o_res.carry = total[32];
    end

endmodule

FILE: design/sequence_resequencer_with_timeout_core.sv
`timescale 1ns / 1ps
// Resequencer: puts numbered messages back in order, holding early ones in a window of
// WINDOW slots, and skips a gap once the gap timer runs out. One item is handled at a time
// and the input is stalled meanwhile. An in-order arrival is decided, then the expected
// number advances, then each stored message drained behind it takes one memory read and
// one output beat. A timeout that skips steps over each missing number (up to WINDOW-1)
// and then drains the stored messages the same way. The design has one shared 32-bit adder
// that steps the expected number and a single read port on the handle memory. Every result
// beat also waits while the output is stalled. No clearing pass after reset; the gap
// timeout register resets to 1000.

module sequence_resequencer_with_timeout_core import seqrs_pkg::*; #(
    parameter int WINDOW = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int SW = $clog2(WINDOW);
    localparam logic [SW:0]   WIN_W     = (SW+1)'(WINDOW);
    localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);

    t_state           r_state, n_state;
    t_in_beat         r_item;
    logic [31:0]      r_exp, n_exp;
    logic [SW-1:0]    r_slot, n_slot;
    logic [WINDOW-1:0] r_valid, n_valid;
    logic [15:0]      r_count, n_count;
    logic             r_running, n_running;
    logic [15:0]      r_gap_ticks;
    logic             r_more, n_more;
    logic             r_out_valid, n_out_valid;
    t_out_beat        r_out, n_out;
    logic [31:0]      r_rd_handle;
    logic [31:0]      r_mem [WINDOW];

    t_alu_op          alu_op;
    t_alu_res         alu_res;
    logic             in_acc;
    logic             out_free;
    logic             out_load;
    logic [SW-1:0]    slot_nxt;
    logic [SW:0]      ins_sum;
    logic [SW-1:0]    slot_ins;
    logic             is_inorder, is_late, is_beyond, is_dup;
    logic [15:0]      cnt_inc;
    logic             expire;
    logic             store_any;
    logic             last_nxt;
    logic             mem_we;
    logic [WINDOW-1:0] valid_left;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign alu_op = (r_state == ST_DECIDE) ? ALU_SUB : ALU_INC;

    seqrs_alu u_alu (
        .i_op  (alu_op),
        .i_seq (r_item.seq_num),
        .i_exp (r_exp),
        .o_res (alu_res)
    );

    // slot of an arriving number from the slot of the expected one
    always_comb begin
        ins_sum = {1'b0, r_slot} + {1'b0, alu_res.sum[SW-1:0]};
        if (ins_sum >= WIN_W) begin
            ins_sum = ins_sum - WIN_W;
        end
        slot_ins = ins_sum[SW-1:0];
    end

    assign slot_nxt   = (r_slot == LAST_SLOT) ? '0 : r_slot + SW'(1);
    assign is_inorder = (alu_res.sum == 32'd0);
    assign is_late    = !alu_res.carry;
    assign is_beyond  = alu_res.carry && (alu_res.sum >= 32'(WINDOW));
    assign is_dup     = r_valid[slot_ins];
    assign store_any  = |r_valid;
    assign last_nxt   = !r_valid[slot_nxt];
    assign cnt_inc    = (r_count != 16'hFFFF) ? r_count + 16'd1 : r_count;
    assign expire     = (cnt_inc >= r_gap_ticks);
    assign valid_left = r_valid & ~(WINDOW'(1) << r_slot);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!r_item.func) begin
                    if (is_inorder) begin
                        if (out_free) n_state = ST_ADV;
                    end else if (is_late || is_beyond || is_dup) begin
                        if (out_free) n_state = ST_IDLE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (r_running && expire && store_any) begin
                    n_state = ST_SKIP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_ADV: begin
                n_state = r_more ? ST_DRAIN_RD : ST_IDLE;
            end
            ST_SKIP: begin
                if (r_valid[r_slot]) n_state = ST_DRAIN_RD;
            end
            ST_DRAIN_RD: begin
                n_state = ST_DRAIN_OUT;
            end
            ST_DRAIN_OUT: begin
                if (out_free) n_state = last_nxt ? ST_IDLE : ST_DRAIN_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_exp     = r_exp;
        n_slot    = r_slot;
        n_valid   = r_valid;
        n_count   = r_count;
        n_running = r_running;
        n_more    = r_more;
        n_out     = r_out;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        case (r_state)
            ST_DECIDE: begin
                if (!r_item.func) begin
                    n_out.out_seq    = r_item.seq_num;
                    n_out.out_handle = r_item.payload_handle;
                    n_out.last       = 1'b1;
                    n_out.status     = STS_DELIVERED;
                    if (is_inorder) begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            n_out.last = last_nxt;
                            n_more     = !last_nxt;
                            n_count    = '0;
                            n_running  = 1'b1;
                        end
                    end else if (is_late) begin
                        out_load     = out_free;
                        n_out.status = STS_LATE;
                    end else if (is_beyond) begin
                        out_load     = out_free;
                        n_out.status = STS_BEYOND;
                    end else if (is_dup) begin
                        out_load     = out_free;
                        n_out.status = STS_DUP;
                    end else begin
                        mem_we            = 1'b1;
                        n_valid[slot_ins] = 1'b1;
                        if (!store_any) begin
                            n_count   = '0;
                            n_running = 1'b1;
                        end
                    end
                end else if (r_running) begin
                    n_count = cnt_inc;
                    if (expire) n_running = 1'b0;
                end
            end
            ST_ADV: begin
                n_exp  = alu_res.sum;
                n_slot = alu_res.carry ? '0 : slot_nxt;
            end
            ST_SKIP: begin
                if (!r_valid[r_slot]) begin
                    n_exp  = alu_res.sum;
                    n_slot = alu_res.carry ? '0 : slot_nxt;
                end
            end
            ST_DRAIN_OUT: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    n_out.status     = STS_DELIVERED;
                    n_out.out_seq    = r_exp;
                    n_out.out_handle = r_rd_handle;
                    n_out.last       = last_nxt;
                    n_valid[r_slot]  = 1'b0;
                    n_exp            = alu_res.sum;
                    n_slot           = alu_res.carry ? '0 : slot_nxt;
                    // restart the timer while messages are still held
                    if (last_nxt && (|valid_left)) begin
                        n_count   = '0;
                        n_running = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        // a waiting beat keeps its payload
        if (!out_load) begin
            n_out = r_out;
        end
        n_out_valid = out_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_exp       <= '0;
            r_slot      <= '0;
            r_valid     <= '0;
            r_count     <= '0;
            r_running   <= 1'b0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
            r_gap_ticks <= 16'd1000;
        end else begin
            r_state     <= n_state;
            r_exp       <= n_exp;
            r_slot      <= n_slot;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_running   <= n_running;
            r_more      <= n_more;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_gap_ticks <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        r_out <= n_out;
    end

    // handle store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[slot_ins] <= r_item.payload_handle;
        end
        if (r_state == ST_DRAIN_RD) begin
            r_rd_handle <= r_mem[r_slot];
        end
    end

    a_drain_reads_held_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN_RD) |-> r_valid[r_slot])
        else $error("drain read of an empty slot");

    a_no_overwrite_held_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !out_load)
        else $error("result loaded over a stalled beat");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= LAST_SLOT)
        else $error("expected slot out of range");

    a_skip_needs_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SKIP) |-> (|r_valid))
        else $error("gap skip with an empty store");

endmodule
